@@ rtl/core/affine_matrix_from_scale_skew_top_macros.svh @@
// Assertion macros for the affine matrix block.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef AFFINE_MATRIX_FROM_SCALE_SKEW_TOP_MACROS_SVH
`define AFFINE_MATRIX_FROM_SCALE_SKEW_TOP_MACROS_SVH

// Same-cycle implication, muted while reset is held.
`define AMSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, muted while reset is held.
`define AMSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/amss_pkg.sv @@
// Package of the affine matrix block: request and result types, sine
// polynomial constants and the 32-bit saturation helper. No dependencies.
package amss_pkg;

    localparam int ANGLE_BITS_DEF = 16;

    // Odd polynomial for one quadrant of sine, Q2.30
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd688904866;
    localparam logic [26:0] POLY_C = 27'd76016977;
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] pivot_x;
        logic signed [31:0] pivot_y;
        logic        [15:0] skew_x_angle;
        logic        [15:0] skew_y_angle;
        logic signed [31:0] scale_x;
        logic signed [31:0] scale_y;
    } t_req;

    typedef struct packed {
        logic signed [31:0] mat_a;
        logic signed [31:0] mat_b;
        logic signed [31:0] mat_c;
        logic signed [31:0] mat_d;
        logic signed [31:0] mat_tx;
        logic signed [31:0] mat_ty;
        logic               overflow_flag;
    } t_rsp;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } t_sat;

    // Clamp to the signed 32-bit range, flag when clamped
    function automatic t_sat sat32(input logic signed [63:0] v);
        t_sat r;
        if (v > 64'sd2147483647) begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < -64'sd2147483648) begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end else begin
            r.val = 32'(v);
            r.ovf = 1'b0;
        end
        return r;
    endfunction

endpackage

@@ rtl/core/amss_if.sv @@
// Request and result channel interfaces of the affine matrix block.
// Depends on amss_pkg for the payload types.
interface amss_req_if;
    import amss_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface amss_rsp_if;
    import amss_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/affine_matrix_from_scale_skew_top.sv @@
// Affine matrix from scale, skew and translation: eleven register stages.
// Takes one request per cycle while the output is not stalled.
// Each stage advances independently, so bubbles close up and a request is
// taken while a finished result still waits on the output register.
// Reset (i_rst_n low, synchronous) clears every stage valid; payload is not reset.
// Depends on amss_pkg, amss_if.sv and affine_matrix_from_scale_skew_top_macros.svh.
`include "affine_matrix_from_scale_skew_top_macros.svh"

module affine_matrix_from_scale_skew_top #(
    parameter int ANGLE_BITS = amss_pkg::ANGLE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    amss_req_if.sink    i_req,
    amss_rsp_if.source  o_rsp
);
    import amss_pkg::*;

    localparam int NS = 11;
    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] QTR = AB'(1) << (AB - 2);
    localparam logic signed [31:0] TRIG_ONE = 32'sd1073741824;

    // Values that ride alongside the trig lanes
    typedef struct packed {
        logic signed [32:0] bx;
        logic signed [32:0] by;
        logic signed [33:0] xx;
        logic signed [33:0] yy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } t_carry;

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    // Lane order: 0 cos(skew_y), 1 sin(skew_y), 2 -sin(skew_x), 3 cos(skew_x)
    logic [30:0]        r_z   [4][4];
    logic               r_ng  [4][4];
    logic [30:0]        r_z2a [4];
    logic [30:0]        r_z2b [4];
    logic [29:0]        r_t1  [4];
    logic [30:0]        r_t2  [4];
    logic signed [31:0] r_trig[4];
    logic signed [63:0] r_pr  [4];
    logic [33:0]        r_rm  [4];
    logic               r_rs  [4];
    logic signed [31:0] r_cf  [3][4];
    logic [3:0]         r_co  [3];
    logic signed [65:0] r_xp  [4];
    logic [49:0]        r_cm  [4];
    logic               r_cs  [4];
    t_carry             r_cr  [NS-1];
    t_rsp               r_out;

    // Stage-one next values
    logic [AB-1:0] n_phx, n_phy;
    logic [AB-1:0] n_ph [4];
    logic [30:0]   n_z  [4];
    logic          n_ng [4];
    t_carry        n_cr;

    // ------------------------------------------------------------------
    // Flow control: a stage takes new data when empty or when it drains.
    // ------------------------------------------------------------------
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || o_rsp.ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign i_req.ready = w_en[0];
    assign o_rsp.valid = r_vld[NS-1];
    assign o_rsp.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_req.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: angle to phase, quadrant fold, offsets at full width.
    // A 16-bit angle scaled to AB phase bits is bits [AB+15:16] of angle<<AB.
    // ------------------------------------------------------------------
    always_comb begin
        logic [AB-1:0] phase;
        logic [29:0]   frac;
        n_phx = AB'(((AB + 16)'(i_req.data.skew_x_angle) << AB) >> 16);
        n_phy = AB'(((AB + 16)'(i_req.data.skew_y_angle) << AB) >> 16);
        n_ph[0] = n_phy + QTR;
        n_ph[1] = n_phy;
        n_ph[2] = n_phx;
        n_ph[3] = n_phx + QTR;
        for (int j = 0; j < 4; j++) begin
            phase = n_ph[j];
            frac  = 30'(phase[AB-3:0]) << (32 - AB);
            // odd quadrants mirror, upper half negates
            n_z[j]  = phase[AB-2] ? (ONE_Q30 - {1'b0, frac}) : {1'b0, frac};
            n_ng[j] = (j == 2) ? !phase[AB-1] : phase[AB-1];
        end
        n_cr.bx = 33'(i_req.data.pos_x) + 33'(i_req.data.origin_x);
        n_cr.by = 33'(i_req.data.pos_y) + 33'(i_req.data.origin_y);
        n_cr.xx = -34'(i_req.data.origin_x) - 34'(i_req.data.pivot_x);
        n_cr.yy = -34'(i_req.data.origin_y) - 34'(i_req.data.pivot_y);
        n_cr.sx = i_req.data.scale_x;
        n_cr.sy = i_req.data.scale_y;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_cr[0] <= n_cr;
            for (int j = 0; j < 4; j++) begin
                r_z[0][j]  <= n_z[j];
                r_ng[0][j] <= n_ng[j];
            end
        end
        // carry the offsets and scales down the pipe
        for (int k = 1; k < NS - 1; k++) begin
            if (w_en[k]) begin
                r_cr[k] <= r_cr[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 5: quarter-sine polynomial, one product per stage.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic [61:0] p0;
        logic [57:0] p1;
        logic [60:0] p2;
        logic [61:0] p3;
        logic [31:0] s;
        for (int j = 0; j < 4; j++) begin
            if (w_en[1]) begin
                p0 = r_z[0][j] * r_z[0][j];
                r_z2a[j]   <= p0[60:30];
                r_z[1][j]  <= r_z[0][j];
                r_ng[1][j] <= r_ng[0][j];
            end
            if (w_en[2]) begin
                p1 = POLY_C * r_z2a[j];
                r_t1[j]    <= POLY_B - 30'(p1[57:30]);
                r_z2b[j]   <= r_z2a[j];
                r_z[2][j]  <= r_z[1][j];
                r_ng[2][j] <= r_ng[1][j];
            end
            if (w_en[3]) begin
                p2 = r_t1[j] * r_z2b[j];
                r_t2[j]    <= POLY_A - 31'(p2[60:30]);
                r_z[3][j]  <= r_z[2][j];
                r_ng[3][j] <= r_ng[2][j];
            end
            if (w_en[4]) begin
                p3 = r_t2[j] * r_z[3][j];
                s  = p3[61:30];
                r_trig[j] <= r_ng[3][j] ? -$signed(s) : $signed(s);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 6 to 8: coefficient = round(trig * scale / 2^30), saturate.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic [63:0]        mag;
        logic [63:0]        rsum;
        logic signed [34:0] v;
        t_sat               st;
        for (int j = 0; j < 4; j++) begin
            if (w_en[5]) begin
                r_pr[j] <= r_trig[j] * ((j < 2) ? r_cr[4].sx : r_cr[4].sy);
            end
            if (w_en[6]) begin
                mag  = r_pr[j][63] ? 64'(-r_pr[j]) : 64'(r_pr[j]);
                rsum = mag + (64'd1 << 29);
                r_rm[j] <= rsum[63:30];
                r_rs[j] <= r_pr[j][63];
            end
            if (w_en[7]) begin
                v  = r_rs[j] ? -$signed({1'b0, r_rm[j]}) : $signed({1'b0, r_rm[j]});
                st = sat32(64'(v));
                r_cf[0][j] <= st.val;
                r_co[0][j] <= st.ovf;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 9 to 11: cross terms round(coef * offset / 2^16), sum, clamp.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        logic [65:0]        xmag;
        logic [65:0]        xsum;
        logic signed [50:0] tm [4];
        logic signed [52:0] sum_x, sum_y;
        t_sat               sa, sb;
        if (w_en[8]) begin
            r_xp[0] <= r_cf[0][0] * r_cr[7].xx;
            r_xp[1] <= r_cf[0][1] * r_cr[7].xx;
            r_xp[2] <= r_cf[0][2] * r_cr[7].yy;
            r_xp[3] <= r_cf[0][3] * r_cr[7].yy;
            r_cf[1] <= r_cf[0];
            r_co[1] <= r_co[0];
        end
        if (w_en[9]) begin
            for (int j = 0; j < 4; j++) begin
                xmag = r_xp[j][65] ? 66'(-r_xp[j]) : 66'(r_xp[j]);
                xsum = xmag + (66'd1 << 15);
                r_cm[j] <= xsum[65:16];
                r_cs[j] <= r_xp[j][65];
            end
            r_cf[2] <= r_cf[1];
            r_co[2] <= r_co[1];
        end
        if (w_en[10]) begin
            for (int j = 0; j < 4; j++) begin
                tm[j] = r_cs[j] ? -$signed({1'b0, r_cm[j]}) : $signed({1'b0, r_cm[j]});
            end
            sum_x = 53'(r_cr[9].bx) + 53'(tm[0]) + 53'(tm[2]);
            sum_y = 53'(r_cr[9].by) + 53'(tm[3]) + 53'(tm[1]);
            sa = sat32(64'(sum_x));
            sb = sat32(64'(sum_y));
            r_out.mat_a         <= r_cf[2][0];
            r_out.mat_b         <= r_cf[2][1];
            r_out.mat_c         <= r_cf[2][2];
            r_out.mat_d         <= r_cf[2][3];
            r_out.mat_tx        <= sa.val;
            r_out.mat_ty        <= sb.val;
            r_out.overflow_flag <= (|r_co[2]) || sa.ovf || sb.ovf;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `AMSS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n,
        i_req.valid && i_req.ready, r_vld[0],
        "accepted request missing from first stage")

    `AMSS_ASSERT_IMP(a_full_stall_blocks, i_clk, i_rst_n,
        (&r_vld) && !o_rsp.ready, !i_req.ready,
        "request taken while every stage is held")

    `AMSS_ASSERT_IMP(a_trig_range, i_clk, i_rst_n, r_vld[4],
        (r_trig[0] <= TRIG_ONE) && (r_trig[0] >= -TRIG_ONE) &&
        (r_trig[1] <= TRIG_ONE) && (r_trig[1] >= -TRIG_ONE) &&
        (r_trig[2] <= TRIG_ONE) && (r_trig[2] >= -TRIG_ONE) &&
        (r_trig[3] <= TRIG_ONE) && (r_trig[3] >= -TRIG_ONE),
        "trig value beyond unit range")

endmodule
